/* rtl/wtws_pkg.sv */
// Package for the windowed time-weighted statistics block.
// Holds the sizing constants, the result row type and the saturation helpers.
// No dependencies; every RTL file of the block imports it.
package wtws_pkg;

    localparam int TIME_BITS   = 32;
    localparam int VALUE_BITS  = 32;
    localparam int MAX_WINDOWS = 16;
    localparam int CNT_BITS    = $clog2(MAX_WINDOWS + 1);
    localparam int SUM_BITS    = 64;

    // A weight lies within plus or minus one full time range.
    localparam int WGT_BITS    = TIME_BITS + 2;
    // A partial span can reach twice the time range.
    localparam int SPAN_BITS   = TIME_BITS + 3;
    localparam int PROD_BITS   = VALUE_BITS + WGT_BITS;

    localparam int unsigned PERIOD_RESET = 1000;

    localparam logic signed [SUM_BITS-1:0] SMAX = {1'b0, {(SUM_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS:0]   SMAX_X = {2'b00, {(SUM_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS:0]   SMIN_X = -SMAX_X;
    localparam logic signed [SUM_BITS-1:0] VMAX =
        {{(SUM_BITS-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] VMIN = -VMAX - 64'sd1;

    // One closed window.
    typedef struct packed {
        logic        [TIME_BITS-1:0]  window_end;
        logic signed [VALUE_BITS-1:0] time_average;
        logic        [31:0]           event_count;
        logic signed [VALUE_BITS-1:0] max_value;
        logic signed [VALUE_BITS-1:0] min_value;
        logic signed [SUM_BITS-1:0]   value_sum;
        logic signed [VALUE_BITS-1:0] mean_value;
        logic                         stats_valid;
        logic                         zero_span;
        logic                         windows_skipped;
        logic                         last;
    } row_t;

    // Add that saturates to the symmetric range of the sums.
    function automatic logic signed [SUM_BITS-1:0] sat_add(
        input logic signed [SUM_BITS-1:0] a,
        input logic signed [SUM_BITS-1:0] b
    );
        logic signed [SUM_BITS:0] s;
        s = {a[SUM_BITS-1], a} + {b[SUM_BITS-1], b};
        if (s > SMAX_X) begin
            return SMAX;
        end
        if (s < SMIN_X) begin
            return -SMAX;
        end
        return s[SUM_BITS-1:0];
    endfunction

    // Clamp a quotient to the value range.
    function automatic logic signed [VALUE_BITS-1:0] clampv(
        input logic signed [SUM_BITS-1:0] x
    );
        logic signed [SUM_BITS-1:0] c;
        c = x;
        if (x > VMAX) begin
            c = VMAX;
        end
        if (x < VMIN) begin
            c = VMIN;
        end
        return c[VALUE_BITS-1:0];
    endfunction

    // A period of zero acts as one.
    function automatic logic [TIME_BITS-1:0] eff_period(input logic [31:0] p);
        logic [TIME_BITS-1:0] m;
        m = p[TIME_BITS-1:0];
        return (m == '0) ? TIME_BITS'(1) : m;
    endfunction

endpackage

/* rtl/wtws_mul.sv */
// Bit-serial saturating multiplier of a value by a signed weight.
// One multiplier bit per cycle; the result saturates to the sum range.
// Depends on wtws_pkg.
module wtws_mul import wtws_pkg::*; (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [VALUE_BITS-1:0] a,
    input  logic signed [WGT_BITS-1:0]   b,
    output logic                         done,
    output logic signed [SUM_BITS-1:0]   prod
);

    localparam int ITER_BITS = $clog2(WGT_BITS);

    logic                  busy_reg;
    logic                  done_reg;
    logic [ITER_BITS-1:0]  cnt_reg;
    logic                  neg_reg;
    logic [PROD_BITS-1:0]  mcand_reg;
    logic [WGT_BITS-1:0]   mplier_reg;
    logic [PROD_BITS-1:0]  acc_reg;

    logic [VALUE_BITS:0]   a_x;
    logic [WGT_BITS:0]     b_x;
    logic [SUM_BITS-1:0]   mag;

    // Magnitudes of the operands, one bit wider so the most negative value fits.
    assign a_x = a[VALUE_BITS-1] ? -{a[VALUE_BITS-1], a} : {a[VALUE_BITS-1], a};
    assign b_x = b[WGT_BITS-1] ? -{b[WGT_BITS-1], b} : {b[WGT_BITS-1], b};

    // Control sequencing.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= ITER_BITS'(WGT_BITS - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift-and-add datapath.
    always_ff @(posedge clk) begin
        if (start) begin
            mcand_reg  <= PROD_BITS'(a_x[VALUE_BITS-1:0]);
            mplier_reg <= b_x[WGT_BITS-1:0];
            acc_reg    <= '0;
            neg_reg    <= a[VALUE_BITS-1] ^ b[WGT_BITS-1];
        end else if (busy_reg) begin
            if (mplier_reg[0]) begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= {mcand_reg[PROD_BITS-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[WGT_BITS-1:1]};
        end
    end

    // Saturate the magnitude and apply the sign.
    assign mag  = (acc_reg > PROD_BITS'(SMAX)) ? SMAX : acc_reg[SUM_BITS-1:0];
    assign prod = neg_reg ? -$signed(mag) : $signed(mag);
    assign done = done_reg;

endmodule

/* rtl/wtws_div.sv */
// Bit-serial signed divider, restoring, one quotient bit per cycle.
// Quotient truncates toward zero; the remainder is given as a magnitude.
// Depends on wtws_pkg.
module wtws_div import wtws_pkg::*; (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [SUM_BITS-1:0]  dividend,
    input  logic signed [SPAN_BITS-1:0] divisor,
    output logic                        done,
    output logic signed [SUM_BITS-1:0]  quot,
    output logic [SPAN_BITS-2:0]        rem
);

    localparam int DM_BITS   = SPAN_BITS - 1;
    localparam int ITER_BITS = $clog2(SUM_BITS);

    logic                  busy_reg;
    logic                  done_reg;
    logic [ITER_BITS-1:0]  cnt_reg;
    logic                  neg_reg;
    logic [DM_BITS-1:0]    dvs_reg;
    logic [DM_BITS-1:0]    rem_reg;
    logic [SUM_BITS-1:0]   quo_reg;

    logic [SUM_BITS:0]     dd_x;
    logic [SPAN_BITS:0]    dv_x;
    logic [DM_BITS:0]      shifted;
    logic                  fits;

    assign dd_x = dividend[SUM_BITS-1] ? -{dividend[SUM_BITS-1], dividend}
                                       : {dividend[SUM_BITS-1], dividend};
    assign dv_x = divisor[SPAN_BITS-1] ? -{divisor[SPAN_BITS-1], divisor}
                                       : {divisor[SPAN_BITS-1], divisor};

    // One trial subtraction per cycle.
    assign shifted = {rem_reg, quo_reg[SUM_BITS-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};

    // Control sequencing.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= ITER_BITS'(SUM_BITS - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift registers.
    always_ff @(posedge clk) begin
        if (start) begin
            dvs_reg <= dv_x[DM_BITS-1:0];
            rem_reg <= '0;
            quo_reg <= dd_x[SUM_BITS-1:0];
            neg_reg <= dividend[SUM_BITS-1] ^ divisor[SPAN_BITS-1];
        end else if (busy_reg) begin
            rem_reg <= fits ? DM_BITS'(shifted - {1'b0, dvs_reg}) : shifted[DM_BITS-1:0];
            quo_reg <= {quo_reg[SUM_BITS-2:0], fits};
        end
    end

    assign quot = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);
    assign rem  = rem_reg;
    assign done = done_reg;

endmodule

/* rtl/windowed_time_weighted_stats_top.sv */
// Windowed time-weighted statistics, top level.
// Uses wtws_pkg, wtws_mul and wtws_div.
//
// Usage:
//   Input stream s_axis: tuser[0] is the operation (0 sample, 1 flush),
//   tdata holds the timestamp and the sample value. Output stream m_axis
//   carries one closed window per transfer; tlast marks the final window
//   caused by one input transfer. The cfg channel loads the window period
//   and restarts the boundary at one period; it is taken only while idle.
//   A sample that crosses no boundary has the old value folded in by the
//   bit-serial multiplier. Each closed window takes a fold plus up to two
//   serial divisions (average and mean), and a skip over surplus
//   boundaries adds one more division; the shared divider sets the rate.
//   After reset the period is 1000 ticks and no value is held. One output
//   register holds a result; while the receiver stalls, the next window
//   waits in its closing step and no new input is taken until the last
//   window of the current one is in the output register.
module windowed_time_weighted_stats_top import wtws_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,   // time_req[31:0], value[63:32]
    input  logic [0:0]   s_axis_tuser,   // op[0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // window_end[31:0], time_average[63:32], event_count[95:64],
    // max_value[127:96], min_value[159:128], value_sum[223:160], mean_value[255:224]
    output logic [255:0] m_axis_tdata,
    // stats_valid[0], zero_span[1], windows_skipped[2]
    output logic [2:0]   m_axis_tuser,
    output logic         m_axis_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data
);

    typedef enum logic [11:0] {
        S_IDLE    = 12'b000000000001,
        S_WIN     = 12'b000000000010,
        S_FOLD    = 12'b000000000100,
        S_FMUL    = 12'b000000001000,
        S_AVG     = 12'b000000010000,
        S_DAVG    = 12'b000000100000,
        S_DMEAN   = 12'b000001000000,
        S_EMIT    = 12'b000010000000,
        S_DSKIP   = 12'b000100000000,
        S_LOAD    = 12'b001000000000,
        S_SAMPLE  = 12'b010000000000,
        S_SAMPEND = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    // Block state that survives between inputs.
    logic [TIME_BITS-1:0]         per_reg;
    logic [TIME_BITS-1:0]         nb_reg;
    logic [TIME_BITS-1:0]         lt_reg;
    logic                         seen_reg;
    logic                         hv_reg;
    logic                         mmv_reg;
    logic signed [VALUE_BITS-1:0] lv_reg;
    logic [31:0]                  events_reg;
    logic [31:0]                  rc_reg;
    logic signed [SUM_BITS-1:0]   ws_reg;
    logic signed [SUM_BITS-1:0]   rs_reg;
    logic signed [VALUE_BITS-1:0] max_reg;
    logic signed [VALUE_BITS-1:0] min_reg;

    // Per-input working registers.
    logic                         op_reg;
    logic [TIME_BITS-1:0]         t_reg;
    logic signed [VALUE_BITS-1:0] v_reg;
    logic [CNT_BITS-1:0]          win_cnt_reg;
    logic                         in_win_reg;
    logic [TIME_BITS-1:0]         ct_reg;
    logic signed [SPAN_BITS-1:0]  span_reg;
    logic signed [WGT_BITS-1:0]   weight_reg;
    logic signed [VALUE_BITS-1:0] avg_reg;
    logic signed [VALUE_BITS-1:0] mean_reg;
    logic                         cont_reg;
    logic                         skip_reg;
    row_t                         row_reg;
    row_t                         out_reg;
    logic                         out_valid_reg;

    logic                         in_xfer;
    logic                         cfg_xfer;
    logic                         slot_free;
    logic                         mul_start;
    logic                         mul_done;
    logic signed [SUM_BITS-1:0]   mul_prod;
    logic                         div_start;
    logic signed [SUM_BITS-1:0]   div_a;
    logic signed [SPAN_BITS-1:0]  div_b;
    logic                         div_done;
    logic signed [SUM_BITS-1:0]   div_q;
    logic [SPAN_BITS-2:0]         div_r;

    logic [TIME_BITS-1:0]         in_time;
    logic                         partial;
    logic [TIME_BITS-1:0]         ct_c;
    logic signed [SPAN_BITS-1:0]  ct_x, per_x, lt_x, t_x, nb_x, from_a, from_c;
    logic signed [SPAN_BITS-1:0]  span_c, wwin_c, wsmp_c;
    logic [TIME_BITS-1:0]         nb_adv;
    logic                         cont_c;
    logic [CNT_BITS-1:0]          cnt_plus;
    logic [TIME_BITS-1:0]         skip_lt;
    logic                         avg_needed;

    assign in_time   = s_axis_tdata[TIME_BITS-1:0];
    assign cfg_ready = (state_reg == S_IDLE);
    assign s_axis_tready = (state_reg == S_IDLE) && !cfg_valid;
    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign slot_free = !out_valid_reg || m_axis_tready;

    // Window geometry for the current close.
    always_comb begin
        t_x     = SPAN_BITS'(t_reg);
        nb_x    = SPAN_BITS'(nb_reg);
        per_x   = SPAN_BITS'(per_reg);
        lt_x    = SPAN_BITS'(lt_reg);
        partial = t_reg < nb_reg;
        ct_c    = partial ? t_reg : nb_reg;
        ct_x    = SPAN_BITS'(ct_c);
        span_c  = partial ? (t_x - nb_x + per_x) : per_x;
        from_a  = ct_x - per_x;
        from_c  = (lt_x > from_a) ? lt_x : from_a;
        wwin_c  = seen_reg ? (ct_x - from_c) : '0;
        wsmp_c  = t_x - lt_x;
        nb_adv  = nb_reg + per_reg;
        cont_c  = t_reg >= nb_adv;
        cnt_plus = win_cnt_reg + 1'b1;
        skip_lt = t_reg - TIME_BITS'(div_r);
        avg_needed = hv_reg && (span_reg != '0);
    end

    // Divider and multiplier requests.
    always_comb begin
        mul_start = (state_reg == S_FOLD) && hv_reg;
        div_start = 1'b0;
        div_a     = ws_reg;
        div_b     = span_reg;
        unique case (state_reg)
            S_AVG:
            begin
                if (avg_needed) begin
                    div_start = 1'b1;
                end else if (hv_reg) begin
                    div_start = 1'b1;
                    div_a     = rs_reg;
                    div_b     = SPAN_BITS'(rc_reg);
                end
            end
            S_DAVG:
            begin
                div_start = div_done;
                div_a     = rs_reg;
                div_b     = SPAN_BITS'(rc_reg);
            end
            S_EMIT:
            begin
                div_start = cont_c && (cnt_plus == CNT_BITS'(MAX_WINDOWS));
                div_a     = SUM_BITS'(t_reg - nb_adv);
                div_b     = SPAN_BITS'(per_reg);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer) begin
                    state_next = (s_axis_tuser[0] || in_time >= nb_reg) ? S_WIN : S_SAMPLE;
                end
            end
            S_WIN:    state_next = S_FOLD;
            S_SAMPLE: state_next = (seen_reg && lt_reg != t_reg) ? S_FOLD : S_SAMPEND;
            S_FOLD:
            begin
                if (hv_reg) begin
                    state_next = S_FMUL;
                end else begin
                    state_next = in_win_reg ? S_AVG : S_SAMPEND;
                end
            end
            S_FMUL:
            begin
                if (mul_done) begin
                    state_next = in_win_reg ? S_AVG : S_SAMPEND;
                end
            end
            S_AVG:
            begin
                if (avg_needed) begin
                    state_next = S_DAVG;
                end else begin
                    state_next = hv_reg ? S_DMEAN : S_EMIT;
                end
            end
            S_DAVG:   state_next = div_done ? S_DMEAN : S_DAVG;
            S_DMEAN:  state_next = div_done ? S_EMIT : S_DMEAN;
            S_EMIT:   state_next = div_start ? S_DSKIP : S_LOAD;
            S_DSKIP:  state_next = div_done ? S_LOAD : S_DSKIP;
            S_LOAD:
            begin
                if (slot_free) begin
                    priority if (cont_reg && !skip_reg) begin
                        state_next = S_WIN;
                    end else if (!op_reg) begin
                        state_next = S_SAMPLE;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_SAMPEND: state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // Control registers and the state kept between inputs.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            per_reg       <= TIME_BITS'(PERIOD_RESET);
            nb_reg        <= TIME_BITS'(PERIOD_RESET);
            lt_reg        <= '0;
            seen_reg      <= 1'b0;
            hv_reg        <= 1'b0;
            mmv_reg       <= 1'b0;
            lv_reg        <= '0;
            events_reg    <= '0;
            rc_reg        <= '0;
            ws_reg        <= '0;
            rs_reg        <= '0;
            max_reg       <= '0;
            min_reg       <= '0;
            win_cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;

            // Output register: a new row replaces a taken one.
            if (state_reg == S_LOAD && slot_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (cfg_xfer) begin
                        per_reg <= eff_period(cfg_data);
                        nb_reg  <= eff_period(cfg_data);
                    end
                    win_cnt_reg <= '0;
                end
                S_SAMPLE:
                begin
                    if (events_reg != '1) begin
                        events_reg <= events_reg + 1'b1;
                    end
                end
                S_FOLD:
                begin
                    if (rc_reg != '1) begin
                        rc_reg <= rc_reg + 1'b1;
                    end
                end
                S_FMUL:
                begin
                    if (mul_done) begin
                        ws_reg <= sat_add(ws_reg, mul_prod);
                        rs_reg <= sat_add(rs_reg, SUM_BITS'(lv_reg));
                        if (!mmv_reg) begin
                            max_reg <= lv_reg;
                            min_reg <= lv_reg;
                            mmv_reg <= 1'b1;
                        end else begin
                            if (lv_reg > max_reg) begin
                                max_reg <= lv_reg;
                            end
                            if (lv_reg < min_reg) begin
                                min_reg <= lv_reg;
                            end
                        end
                    end
                end
                S_EMIT:
                begin
                    // Close the window and start the next one.
                    events_reg  <= '0;
                    ws_reg      <= '0;
                    rs_reg      <= '0;
                    rc_reg      <= '0;
                    max_reg     <= lv_reg;
                    min_reg     <= lv_reg;
                    mmv_reg     <= hv_reg;
                    nb_reg      <= nb_adv;
                    lt_reg      <= ct_reg;
                    seen_reg    <= 1'b1;
                    win_cnt_reg <= cnt_plus;
                end
                S_DSKIP:
                begin
                    // Jump past the surplus boundaries in one step.
                    if (div_done) begin
                        lt_reg <= skip_lt;
                        nb_reg <= skip_lt + per_reg;
                    end
                end
                S_SAMPEND:
                begin
                    lt_reg   <= t_reg;
                    seen_reg <= 1'b1;
                    lv_reg   <= v_reg;
                    hv_reg   <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Working payload registers.
    always_ff @(posedge clk) begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer) begin
                    op_reg <= s_axis_tuser[0];
                    t_reg  <= in_time;
                    v_reg  <= s_axis_tdata[32 +: VALUE_BITS];
                end
            end
            S_WIN:
            begin
                in_win_reg <= 1'b1;
                ct_reg     <= ct_c;
                span_reg   <= span_c;
                weight_reg <= WGT_BITS'(wwin_c);
            end
            S_SAMPLE:
            begin
                in_win_reg <= 1'b0;
                weight_reg <= WGT_BITS'(wsmp_c);
            end
            S_AVG:
            begin
                if (!avg_needed) begin
                    avg_reg <= '0;
                end
                if (!hv_reg) begin
                    mean_reg <= '0;
                end
            end
            S_DAVG:
            begin
                if (div_done) begin
                    avg_reg <= clampv(div_q);
                end
            end
            S_DMEAN:
            begin
                if (div_done) begin
                    mean_reg <= clampv(div_q);
                end
            end
            S_EMIT:
            begin
                row_reg.window_end      <= ct_reg;
                row_reg.time_average    <= avg_reg;
                row_reg.event_count     <= events_reg;
                row_reg.max_value       <= hv_reg ? max_reg : '0;
                row_reg.min_value       <= hv_reg ? min_reg : '0;
                row_reg.value_sum       <= hv_reg ? rs_reg : '0;
                row_reg.mean_value      <= mean_reg;
                row_reg.stats_valid     <= hv_reg;
                row_reg.zero_span       <= (span_reg == '0);
                row_reg.windows_skipped <= div_start;
                row_reg.last            <= div_start || !cont_c;
                cont_reg                <= cont_c;
                skip_reg                <= div_start;
            end
            S_LOAD:
            begin
                if (slot_free) begin
                    out_reg <= row_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    wtws_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (lv_reg),
        .b     (weight_reg),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    wtws_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quot     (div_q),
        .rem      (div_r)
    );

    // Output stream.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.mean_value, out_reg.value_sum, out_reg.min_value,
                            out_reg.max_value, out_reg.event_count, out_reg.time_average,
                            out_reg.window_end};
    assign m_axis_tuser  = {out_reg.windows_skipped, out_reg.zero_span, out_reg.stats_valid};
    assign m_axis_tlast  = out_reg.last;

    // The window counter never passes the limit.
    a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
        win_cnt_reg <= CNT_BITS'(MAX_WINDOWS))
        else $error("window counter beyond limit");

    // A skip is always reported on the final window of an input.
    a_skip_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_reg.windows_skipped) |-> out_reg.last)
        else $error("skipped flag on a non-final window");

    // The average division never runs with a zero span.
    a_span_nz: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DAVG) |-> (span_reg != '0))
        else $error("average division with zero span");

    // With no value held, the statistics read as zero.
    a_no_value: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !out_reg.stats_valid) |->
            (out_reg.value_sum == '0 && out_reg.time_average == '0
             && out_reg.mean_value == '0))
        else $error("statistics not zero without a value");

endmodule
